// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/rgb10a2_pkg.sv =====
// package with constants and types for the rgb10a2 packer
`timescale 1ns / 1ps
package rgb10a2_pkg;
    localparam int unsigned ColorW = 10;
    localparam int unsigned AlphaW = 2;
    localparam logic [23:0] ColorMul = 24'd1023;
    localparam logic [23:0] AlphaMul = 24'd3;
    localparam int unsigned ShiftAlpha = 30;
    localparam int unsigned ShiftBlue = 20;
    localparam int unsigned ShiftGreen = 10;

    // per lane product stage result
    typedef struct packed {
        logic        zero;
        logic        sat;
        logic [47:0] prod;
        logic [7:0]  expo;
    } lane_mid_t;
endpackage

// ===== hw/rtl/float_rgba_to_rgb10a2_pack_unit.sv =====
// top level: four lanes, merge into packed word, valid pipeline
// channel | dir | handshake
// s_      | in  | s_valid / s_ready, four float words
// m_      | out | m_valid / m_ready, one packed word
// one pixel per clock while m_ready does not stall it; registered stages: multiply, round, merge register
// throughput set by the lane pipeline, which advances whenever the output can move
// reset clears the valid bits only; a stalled m_ready holds the whole pipe
`timescale 1ns / 1ps
`include "assert_macros.svh"
module float_rgba_to_rgb10a2_pack_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_red_bits,
    input  logic [31:0] s_green_bits,
    input  logic [31:0] s_blue_bits,
    input  logic [31:0] s_alpha_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_packed_word
);
    import rgb10a2_pkg::*;

    logic [2:0] vld_reg, vld_next;
    logic en;
    logic [9:0] r, g, b, a;
    logic [31:0] word_reg;

    assign en = !vld_reg[2] || m_ready;
    assign s_ready = en;
    assign vld_next = {vld_reg[1:0], s_valid};

    rgb10a2_lane u_r (.aclk, .en, .alpha_mode(1'b0), .bits_in(s_red_bits), .code_out(r));
    rgb10a2_lane u_g (.aclk, .en, .alpha_mode(1'b0), .bits_in(s_green_bits), .code_out(g));
    rgb10a2_lane u_b (.aclk, .en, .alpha_mode(1'b0), .bits_in(s_blue_bits), .code_out(b));
    rgb10a2_lane u_a (.aclk, .en, .alpha_mode(1'b1), .bits_in(s_alpha_bits), .code_out(a));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 3'd0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
        if (en) begin
            word_reg <= {a[AlphaW-1:0], b, g, r};
        end
    end

    assign m_valid = vld_reg[2];
    assign m_packed_word = word_reg;

    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_packed_word))
    `ASSERT_IMPL(a_ready, aclk, aresetn, !m_valid, s_ready)
    `ASSERT_NEXT(a_flow, aclk, aresetn, s_ready && vld_reg[1], m_valid)
endmodule

// ===== hw/rtl/rgb10a2_lane.sv =====
// one channel quantiser: multiply stage then round and clamp stage
`timescale 1ns / 1ps
module rgb10a2_lane (
    input  logic        aclk,
    input  logic        en,
    input  logic        alpha_mode,
    input  logic [31:0] bits_in,
    output logic [9:0]  code_out
);
    import rgb10a2_pkg::*;

    lane_mid_t mid_reg, mid_next;
    logic [9:0] code_reg, code_next;
    logic [23:0] mant;
    logic [9:0] maxc;

    always_comb begin
        mant = {1'b1, bits_in[22:0]};
        mid_next.zero = bits_in[31] || (bits_in[30:23] == 8'hff && bits_in[22:0] != 23'd0)
                        || bits_in[30:23] == 8'd0;
        mid_next.sat = !bits_in[31] && bits_in[30:23] >= 8'd127;
        mid_next.prod = mant * (alpha_mode ? AlphaMul : ColorMul);
        mid_next.expo = bits_in[30:23];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mid_reg <= mid_next;
            code_reg <= code_next;
        end
    end

    // value = prod * 2^(expo-150); round to single (24 bits) then to integer
    logic [5:0]  lead;
    logic [47:0] p24;
    logic [47:0] fl;
    logic [8:0]  sh;
    logic [47:0] ival;
    logic [47:0] rem;
    logic [47:0] half;
    logic [10:0] n;
    always_comb begin
        maxc = alpha_mode ? 10'd3 : 10'd1023;
        // product of 24 bit mantissa with <=10 bit const is 34 or fewer bits
        lead = 6'd0;
        for (int i = 0; i < 48; i++) if (mid_reg.prod[i]) lead = 6'(i);
        // round product to 24 significant bits, ties to even
        fl = 48'd0;
        if (lead > 6'd23) begin
            fl = mid_reg.prod >> (lead - 6'd23);
            rem = mid_reg.prod & ((48'd1 << (lead - 6'd23)) - 48'd1);
            half = 48'd1 << (lead - 6'd24);
            if (rem > half || (rem == half && fl[0])) fl = fl + 48'd1;
            fl = fl << (lead - 6'd23);
        end else begin
            fl = mid_reg.prod;
        end
        // shift right by 150-expo
        sh = 9'd150 - {1'b0, mid_reg.expo};
        if (sh > 9'd47) begin
            ival = 48'd0; rem = fl; half = 48'd0; n = 11'd0;
            if (sh == 9'd48) begin
                half = 48'd1 << 47;
                n = (fl > half) ? 11'd1 : 11'd0;
            end
        end else begin
            ival = fl >> sh;
            rem = fl & ((48'd1 << sh) - 48'd1);
            half = (sh == 9'd0) ? 48'd0 : (48'd1 << (sh - 9'd1));
            n = ival[10:0];
            if (sh != 9'd0 && (rem > half || (rem == half && ival[0]))) n = n + 11'd1;
        end
        if (n > {1'b0, maxc}) n = {1'b0, maxc};
        code_next = n[9:0];
        if (mid_reg.zero) code_next = 10'd0;
        else if (mid_reg.sat) code_next = maxc;
    end

    assign code_out = code_reg;
endmodule
